FILE: rtl/sqllx_pkg.sv
// Shared types, codes and keyword table for the SQL byte-stream lexer.
package sqllx_pkg;

  localparam int unsigned OffsetBitsDefault = 16;
  localparam int unsigned KeywordMaxChars   = 8;
  localparam int unsigned NumKeywords       = 30;
  localparam int unsigned MaxRes            = 4;
  localparam int unsigned ResCntBits        = $clog2(MaxRes + 1);
  localparam int unsigned ResIdxBits        = $clog2(MaxRes);
  localparam logic [15:0] FirstLineReset    = 16'd1;
  localparam logic [15:0] SatMax16          = 16'hFFFF;

  localparam logic [5:0] KindIdent = 6'd30;
  localparam logic [5:0] KindInt   = 6'd31;
  localparam logic [5:0] KindReal  = 6'd32;
  localparam logic [5:0] KindStr   = 6'd33;
  localparam logic [5:0] KindEq    = 6'd34;
  localparam logic [5:0] KindNe    = 6'd35;
  localparam logic [5:0] KindLe    = 6'd36;
  localparam logic [5:0] KindLt    = 6'd37;
  localparam logic [5:0] KindGe    = 6'd38;
  localparam logic [5:0] KindGt    = 6'd39;
  localparam logic [5:0] KindComma = 6'd40;
  localparam logic [5:0] KindSemi  = 6'd41;
  localparam logic [5:0] KindLpar  = 6'd42;
  localparam logic [5:0] KindRpar  = 6'd43;
  localparam logic [5:0] KindStar  = 6'd44;
  localparam logic [5:0] KindDot   = 6'd45;
  localparam logic [5:0] KindEnd   = 6'd46;
  localparam logic [5:0] KindNone  = 6'd0;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrBang     = 2'd1;
  localparam logic [1:0] ErrBadChar  = 2'd2;
  localparam logic [1:0] ErrOpenStr  = 2'd3;

  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChQuote = 8'h27;
  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChBang  = 8'h21;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChSemi  = 8'h3B;
  localparam logic [7:0] ChLpar  = 8'h28;
  localparam logic [7:0] ChRpar  = 8'h29;
  localparam logic [7:0] ChStar  = 8'h2A;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChUnder = 8'h5F;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       byte_valid;
    logic       end_of_source;
  } in_t;

  typedef struct packed {
    logic [5:0]  token_kind;
    logic [1:0]  error_code;
    logic [15:0] start_offset;
    logic [15:0] lexeme_length;
    logic [15:0] start_line;
    logic        last_result;
  } out_t;

  // Keywords packed with the last letter in the low byte.
  function automatic logic [63:0] kw_word(input logic [4:0] idx);
    case (idx)
      5'd0:  return 64'("SELECT");
      5'd1:  return 64'("FROM");
      5'd2:  return 64'("WHERE");
      5'd3:  return 64'("INSERT");
      5'd4:  return 64'("INTO");
      5'd5:  return 64'("VALUES");
      5'd6:  return 64'("CREATE");
      5'd7:  return 64'("TABLE");
      5'd8:  return 64'("INDEX");
      5'd9:  return 64'("ON");
      5'd10: return 64'("JOIN");
      5'd11: return 64'("AND");
      5'd12: return 64'("OR");
      5'd13: return 64'("NOT");
      5'd14: return 64'("ORDER");
      5'd15: return 64'("BY");
      5'd16: return 64'("GROUP");
      5'd17: return 64'("HAVING");
      5'd18: return 64'("LIMIT");
      5'd19: return 64'("BEGIN");
      5'd20: return 64'("COMMIT");
      5'd21: return 64'("ROLLBACK");
      5'd22: return 64'("PRIMARY");
      5'd23: return 64'("KEY");
      5'd24: return 64'("NULL");
      5'd25: return 64'("INTEGER");
      5'd26: return 64'("TEXT");
      5'd27: return 64'("REAL");
      5'd28: return 64'("ASC");
      5'd29: return 64'("DESC");
      default: return 64'd0;
    endcase
  endfunction

  function automatic logic [5:0] name_kind(input logic [63:0] buf_v, input logic [3:0] len);
    logic [5:0] k;
    k = KindIdent;
    if (len <= 4'(KeywordMaxChars)) begin
      for (int i = 0; i < NumKeywords; i++) begin
        if (kw_word(5'(i)) == buf_v) k = 6'(i);
      end
    end
    return k;
  endfunction

endpackage

FILE: rtl/sqllx_scan.sv
// Scanner state and per-word token generation for the SQL lexer.
module sqllx_scan #(
  parameter int unsigned OffsetBits = sqllx_pkg::OffsetBitsDefault
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     fire_i,
  input  sqllx_pkg::in_t                           data_i,
  input  logic                                     cfg_fire_i,
  input  logic [15:0]                              cfg_data_i,
  output sqllx_pkg::out_t [sqllx_pkg::MaxRes-1:0]  res_o,
  output logic [sqllx_pkg::ResCntBits-1:0]         res_cnt_o
);

  typedef enum logic [3:0] {
    ModeIdle, ModeIdent, ModeNum, ModeNumDot, ModeReal, ModeStr, ModeStrQ,
    ModeLt, ModeGt, ModeBang, ModeMinus, ModeComment, ModeError
  } mode_e;

  mode_e                 mode_q, mode_d;
  logic [OffsetBits-1:0] pos_q, pos_d, tstart_q, tstart_d;
  logic [15:0]           line_q, line_d, tline_q, tline_d, first_q, first_d;
  logic [15:0]           llen_q, llen_d;
  logic [63:0]           kbuf_q, kbuf_d;
  logic [3:0]            nlen_q, nlen_d;
  logic                  open_q, open_d;

  sqllx_pkg::out_t [sqllx_pkg::MaxRes-1:0] res;
  logic [sqllx_pkg::ResCntBits-1:0]        n;
  logic [7:0]                              c, uc;
  logic                                    fall, alpha, digit;

  function automatic logic [15:0] sat_inc(input logic [15:0] v);
    return (v == sqllx_pkg::SatMax16) ? v : v + 16'd1;
  endfunction

  function automatic logic [15:0] off16(input logic [OffsetBits-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[15:0];
  endfunction

  function automatic sqllx_pkg::out_t mk(input logic [5:0] k, input logic [1:0] e,
                                         input logic [15:0] s, input logic [15:0] l,
                                         input logic [15:0] ln);
    sqllx_pkg::out_t r;
    r.token_kind    = k;
    r.error_code    = e;
    r.start_offset  = s;
    r.lexeme_length = l;
    r.start_line    = ln;
    r.last_result   = 1'b0;
    return r;
  endfunction

  always_comb begin
    mode_d = mode_q; pos_d = pos_q; tstart_d = tstart_q; line_d = line_q;
    tline_d = tline_q; first_d = first_q; llen_d = llen_q; kbuf_d = kbuf_q;
    nlen_d = nlen_q; open_d = open_q;
    res = '0;
    n = '0;
    fall = 1'b0;
    c = data_i.byte_value;
    uc = (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    digit = (c >= 8'h30 && c <= 8'h39);
    if (fire_i && data_i.byte_valid) begin
      open_d = 1'b1;
      case (mode_q)
        ModeIdent: begin
          if (alpha || digit || c == sqllx_pkg::ChUnder) begin
            llen_d = sat_inc(llen_q);
            if (nlen_q < 4'(sqllx_pkg::KeywordMaxChars)) begin
              kbuf_d = {kbuf_q[55:0], uc};
              nlen_d = nlen_q + 4'd1;
            end else begin
              nlen_d = 4'(sqllx_pkg::KeywordMaxChars + 1);
            end
          end else begin
            res[n[1:0]] = mk(sqllx_pkg::name_kind(kbuf_q, nlen_q), sqllx_pkg::ErrNone,
                             off16(tstart_q), llen_q, tline_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeNum: begin
          if (digit) llen_d = sat_inc(llen_q);
          else if (c == sqllx_pkg::ChDot) mode_d = ModeNumDot;
          else begin
            res[n[1:0]] = mk(sqllx_pkg::KindInt, sqllx_pkg::ErrNone, off16(tstart_q),
                             llen_q, tline_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeNumDot: begin
          if (digit) begin
            llen_d = sat_inc(sat_inc(llen_q));
            mode_d = ModeReal;
          end else begin
            res[n[1:0]] = mk(sqllx_pkg::KindInt, sqllx_pkg::ErrNone, off16(tstart_q),
                             llen_q, tline_q);
            n = n + 1'b1;
            res[n[1:0]] = mk(sqllx_pkg::KindDot, sqllx_pkg::ErrNone,
                             off16(pos_q - 1'b1), 16'd1, line_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeReal: begin
          if (digit) llen_d = sat_inc(llen_q);
          else begin
            res[n[1:0]] = mk(sqllx_pkg::KindReal, sqllx_pkg::ErrNone, off16(tstart_q),
                             llen_q, tline_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeStr: begin
          if (c == sqllx_pkg::ChQuote) mode_d = ModeStrQ;
          else llen_d = sat_inc(llen_q);
        end
        ModeStrQ: begin
          if (c == sqllx_pkg::ChQuote) begin
            llen_d = sat_inc(sat_inc(llen_q));
            mode_d = ModeStr;
          end else begin
            res[n[1:0]] = mk(sqllx_pkg::KindStr, sqllx_pkg::ErrNone, off16(tstart_q),
                             llen_q, tline_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeLt, ModeGt, ModeBang: begin
          if (c == sqllx_pkg::ChEq) begin
            res[n[1:0]] = mk((mode_q == ModeLt) ? sqllx_pkg::KindLe :
                             (mode_q == ModeGt) ? sqllx_pkg::KindGe : sqllx_pkg::KindNe,
                             sqllx_pkg::ErrNone, off16(tstart_q), 16'd2, tline_q);
            n = n + 1'b1;
            mode_d = ModeIdle;
          end else if (mode_q == ModeBang) begin
            res[n[1:0]] = mk(sqllx_pkg::KindNone, sqllx_pkg::ErrBang, off16(tstart_q),
                             16'd1, tline_q);
            n = n + 1'b1;
            mode_d = ModeError;
          end else begin
            res[n[1:0]] = mk((mode_q == ModeLt) ? sqllx_pkg::KindLt : sqllx_pkg::KindGt,
                             sqllx_pkg::ErrNone, off16(tstart_q), 16'd1, tline_q);
            n = n + 1'b1;
            fall = 1'b1;
          end
        end
        ModeMinus: begin
          if (c == sqllx_pkg::ChMinus) mode_d = ModeComment;
          else begin
            res[n[1:0]] = mk(sqllx_pkg::KindNone, sqllx_pkg::ErrBadChar, off16(tstart_q),
                             16'd1, tline_q);
            n = n + 1'b1;
            mode_d = ModeError;
          end
        end
        ModeComment: fall = (c == sqllx_pkg::ChLf);
        ModeError: fall = 1'b0;
        default: fall = 1'b1;
      endcase
      if (fall) begin
        mode_d = ModeIdle;
        case (c)
          sqllx_pkg::ChSpace, sqllx_pkg::ChTab, sqllx_pkg::ChCr, sqllx_pkg::ChLf: ;
          sqllx_pkg::ChMinus, sqllx_pkg::ChLt, sqllx_pkg::ChGt, sqllx_pkg::ChBang: begin
            mode_d = (c == sqllx_pkg::ChMinus) ? ModeMinus :
                     (c == sqllx_pkg::ChLt) ? ModeLt :
                     (c == sqllx_pkg::ChGt) ? ModeGt : ModeBang;
            tstart_d = pos_q; tline_d = line_q; llen_d = 16'd1;
          end
          sqllx_pkg::ChQuote: begin
            mode_d = ModeStr;
            tstart_d = pos_q + 1'b1; tline_d = line_q; llen_d = 16'd0;
          end
          sqllx_pkg::ChEq, sqllx_pkg::ChComma, sqllx_pkg::ChSemi, sqllx_pkg::ChLpar,
          sqllx_pkg::ChRpar, sqllx_pkg::ChStar, sqllx_pkg::ChDot: begin
            res[n[1:0]] = mk((c == sqllx_pkg::ChEq) ? sqllx_pkg::KindEq :
                             (c == sqllx_pkg::ChComma) ? sqllx_pkg::KindComma :
                             (c == sqllx_pkg::ChSemi) ? sqllx_pkg::KindSemi :
                             (c == sqllx_pkg::ChLpar) ? sqllx_pkg::KindLpar :
                             (c == sqllx_pkg::ChRpar) ? sqllx_pkg::KindRpar :
                             (c == sqllx_pkg::ChStar) ? sqllx_pkg::KindStar :
                             sqllx_pkg::KindDot,
                             sqllx_pkg::ErrNone, off16(pos_q), 16'd1, line_q);
            n = n + 1'b1;
          end
          default: begin
            if (alpha || c == sqllx_pkg::ChUnder) begin
              mode_d = ModeIdent;
              tstart_d = pos_q; tline_d = line_q; llen_d = 16'd1;
              kbuf_d = {56'd0, uc};
              nlen_d = 4'd1;
            end else if (digit) begin
              mode_d = ModeNum;
              tstart_d = pos_q; tline_d = line_q; llen_d = 16'd1;
            end else begin
              res[n[1:0]] = mk(sqllx_pkg::KindNone, sqllx_pkg::ErrBadChar, off16(pos_q),
                               16'd1, line_q);
              n = n + 1'b1;
              mode_d = ModeError;
            end
          end
        endcase
      end
      if (c == sqllx_pkg::ChLf && line_q != sqllx_pkg::SatMax16) line_d = line_q + 16'd1;
      pos_d = pos_q + 1'b1;
    end
    if (fire_i && data_i.end_of_source) begin
      case (mode_d)
        ModeIdent: begin
          res[n[1:0]] = mk(sqllx_pkg::name_kind(kbuf_d, nlen_d), sqllx_pkg::ErrNone,
                           off16(tstart_d), llen_d, tline_d);
          n = n + 1'b1;
        end
        ModeNum, ModeNumDot, ModeReal, ModeStr, ModeStrQ: begin
          res[n[1:0]] = mk((mode_d == ModeReal) ? sqllx_pkg::KindReal :
                           (mode_d == ModeStr) ? sqllx_pkg::KindNone :
                           (mode_d == ModeStrQ) ? sqllx_pkg::KindStr : sqllx_pkg::KindInt,
                           (mode_d == ModeStr) ? sqllx_pkg::ErrOpenStr : sqllx_pkg::ErrNone,
                           off16(tstart_d), llen_d, tline_d);
          n = n + 1'b1;
          if (mode_d == ModeNumDot) begin
            res[n[1:0]] = mk(sqllx_pkg::KindDot, sqllx_pkg::ErrNone,
                             off16(pos_d - 1'b1), 16'd1, line_d);
            n = n + 1'b1;
          end
        end
        ModeLt, ModeGt, ModeBang, ModeMinus: begin
          res[n[1:0]] = mk((mode_d == ModeLt) ? sqllx_pkg::KindLt :
                           (mode_d == ModeGt) ? sqllx_pkg::KindGt : sqllx_pkg::KindNone,
                           (mode_d == ModeBang) ? sqllx_pkg::ErrBang :
                           (mode_d == ModeMinus) ? sqllx_pkg::ErrBadChar : sqllx_pkg::ErrNone,
                           off16(tstart_d), 16'd1, tline_d);
          n = n + 1'b1;
        end
        default: ;
      endcase
      res[n[1:0]] = mk(sqllx_pkg::KindEnd, sqllx_pkg::ErrNone, off16(pos_d), 16'd0, line_d);
      n = n + 1'b1;
      mode_d = ModeIdle; pos_d = '0; line_d = first_q; tstart_d = '0; tline_d = '0;
      kbuf_d = '0; nlen_d = '0; llen_d = '0; open_d = 1'b0;
    end
    if (n != '0) res[2'(n - 1'b1)].last_result = 1'b1;
    if (cfg_fire_i) begin
      first_d = cfg_data_i;
      if (!open_q) line_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle; pos_q <= '0; tstart_q <= '0;
      line_q <= sqllx_pkg::FirstLineReset; first_q <= sqllx_pkg::FirstLineReset;
      tline_q <= '0; llen_q <= '0; kbuf_q <= '0; nlen_q <= '0; open_q <= 1'b0;
    end else begin
      mode_q <= mode_d; pos_q <= pos_d; tstart_q <= tstart_d; line_q <= line_d;
      first_q <= first_d; tline_q <= tline_d; llen_q <= llen_d; kbuf_q <= kbuf_d;
      nlen_q <= nlen_d; open_q <= open_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = n;

endmodule

FILE: rtl/sql_lexer_byte_stream.sv
// A word's first token is presented in the cycle after the word is accepted.
// Throughput: 1 word per cycle while each word yields at most one token and
// the output is ready; more tokens hold the input until the last one is taken.
// The 4-entry result register after the scanner sets that figure.
// Reset: scanner idle, offset 0, line and first_line 1, result register empty.
module sql_lexer_byte_stream #(
  parameter int unsigned OffsetBits = sqllx_pkg::OffsetBitsDefault
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  sqllx_pkg::in_t  in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output sqllx_pkg::out_t out_data_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [15:0]     cfg_data_i
);

  sqllx_pkg::out_t [sqllx_pkg::MaxRes-1:0] res, q_res_q;
  logic [sqllx_pkg::ResCntBits-1:0]        res_cnt, q_cnt_q;
  logic [sqllx_pkg::ResIdxBits-1:0]        q_head_q;
  logic                                    fire, out_fire;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (q_cnt_q != '0);
  assign out_fire    = out_valid_o && out_ready_i;
  assign in_ready_o  = (q_cnt_q == '0) || ((q_cnt_q == 1) && out_ready_i);
  assign fire        = in_valid_i && in_ready_o;
  assign out_data_o  = q_res_q[q_head_q];

  sqllx_scan #(.OffsetBits(OffsetBits)) u_scan (
    .clk_i, .rst_ni,
    .fire_i     (fire),
    .data_i     (in_data_i),
    .cfg_fire_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .res_o      (res),
    .res_cnt_o  (res_cnt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_cnt_q  <= '0;
      q_head_q <= '0;
    end else if (fire) begin
      q_cnt_q  <= res_cnt;
      q_head_q <= '0;
    end else if (out_fire) begin
      q_cnt_q  <= q_cnt_q - 1'b1;
      q_head_q <= q_head_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) q_res_q <= res;
  end

`ifndef SYNTH
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt_q <= sqllx_pkg::ResCntBits'(sqllx_pkg::MaxRes))
    else $error("result count out of range");
  a_last_on_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && q_cnt_q == 1) |-> out_data_o.last_result)
    else $error("final token lacks last flag");
  a_no_early_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && q_cnt_q > 1) |-> !out_data_o.last_result)
    else $error("last flag before final token");
  a_load_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (q_head_q == '0))
    else $error("head not cleared on new word");
`endif

endmodule
